>>> hw/rtl/pls_pkg.sv
// Package for the positional list store: field widths, command, status and
// micro-operation codes, and the packed beat and control/status structs.
// Depends on nothing; every other RTL file of the block but pls_ram imports it.
package pls_pkg;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 7;
    localparam int ITEM_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;
    localparam int OP_W   = 4;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LENGTH   = 2'd3;

    // Response status codes.
    localparam logic [STAT_W-1:0] RSP_OK      = 2'd0;
    localparam logic [STAT_W-1:0] RSP_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] RSP_FULL    = 2'd2;

    // Micro-operations issued by the controller to the datapath.
    localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
    localparam logic [OP_W-1:0] OP_CHECK    = 4'd1;
    localparam logic [OP_W-1:0] OP_WALK     = 4'd2;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 4'd3;
    localparam logic [OP_W-1:0] OP_INS_A    = 4'd4;
    localparam logic [OP_W-1:0] OP_INS_B    = 4'd5;
    localparam logic [OP_W-1:0] OP_RM_A     = 4'd6;
    localparam logic [OP_W-1:0] OP_RM_RD    = 4'd7;
    localparam logic [OP_W-1:0] OP_RM_MV    = 4'd8;
    localparam logic [OP_W-1:0] OP_RM_FIX   = 4'd9;
    localparam logic [OP_W-1:0] OP_RT       = 4'd10;
    localparam logic [OP_W-1:0] OP_RESP     = 4'd11;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [ITEM_W-1:0] item_in;
    } pls_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ITEM_W-1:0] item_out;
        logic [LEN_W-1:0]  length;
    } pls_out_t;

    typedef struct packed {
        logic            latch;
        logic [OP_W-1:0] op;
    } pls_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [STAT_W-1:0] status;
        logic              pos_one;
        logic              walk_done;
        logic              reloc;
        logic              out_free;
    } pls_sts_t;

endpackage

>>> hw/rtl/positional_list_store_core.sv
// Top level of the positional list store: an ordered list of item words
// addressed by 1-based position. Depends on pls_pkg, pls_ctrl and pls_dpath.
//
//  Channel   Direction  Handshake          Beat
//  s_        in         s_valid/s_ready    pls_in_t  {cmd, position, item_in}
//  m_        out        m_valid/m_ready    pls_out_t {status, item_out, length}
//
// One request is taken at a time. A rejected request or a length read goes
// from the check step straight to the response step; a head insert goes
// through its update step; any other request walks the successor links one
// slot a cycle from the head before its update steps, with read, move and fix
// steps added for a remove that moves the highest slot into the freed one.
// The controller is back in its idle state before the next beat is accepted.
// Reset clears the count, head and tail registers; the slot RAMs are not
// cleared, since no slot is read before it has been written.
// A finished beat waits in the output register; the next request is accepted
// meanwhile and its result holds back until that register has been emptied.
module positional_list_store_core
    import pls_pkg::*;
#(
    // Number of slots; the 7-bit length and position fields allow 2 to 127.
    parameter int DEPTH      = 64,
    // Stored width of an item word, 1 to 32; wider input bits are dropped.
    parameter int ITEM_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pls_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pls_out_t m_data
);

    // Controller and datapath talk only through these two structs.
    pls_ctl_t ctl;
    pls_sts_t sts;

    pls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    pls_dpath #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctl     (ctl),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hw/rtl/pls_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/pls_ctrl.sv
// Controller of the positional list store: sequences each request through
// check, optional walk and update, and response steps. Depends on pls_pkg.
module pls_ctrl
    import pls_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pls_sts_t sts,
    output pls_ctl_t ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_WALK     = 4'd2;
    localparam logic [3:0] S_INS_HEAD = 4'd3;
    localparam logic [3:0] S_INS_A    = 4'd4;
    localparam logic [3:0] S_INS_B    = 4'd5;
    localparam logic [3:0] S_RM_A     = 4'd6;
    localparam logic [3:0] S_RM_RD    = 4'd7;
    localparam logic [3:0] S_RM_MV    = 4'd8;
    localparam logic [3:0] S_RM_FIX   = 4'd9;
    localparam logic [3:0] S_RT       = 4'd10;
    localparam logic [3:0] S_RESP     = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl.latch  = 1'b0;
        ctl.op     = OP_IDLE;
        case (state_reg)
            S_IDLE: begin
                ctl.latch = s_valid;
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                ctl.op = OP_CHECK;
                if (sts.status != RSP_OK || sts.cmd == CMD_LENGTH) begin
                    state_next = S_RESP;
                end else if (sts.cmd == CMD_INSERT && sts.pos_one) begin
                    state_next = S_INS_HEAD;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                ctl.op = OP_WALK;
                if (sts.walk_done) begin
                    case (sts.cmd)
                        CMD_INSERT: state_next = S_INS_A;
                        CMD_REMOVE: state_next = S_RM_A;
                        default:    state_next = S_RT;
                    endcase
                end
            end
            S_INS_HEAD: begin
                ctl.op     = OP_INS_HEAD;
                state_next = S_RESP;
            end
            S_INS_A: begin
                ctl.op     = OP_INS_A;
                state_next = S_INS_B;
            end
            S_INS_B: begin
                ctl.op     = OP_INS_B;
                state_next = S_RESP;
            end
            S_RM_A: begin
                ctl.op     = OP_RM_A;
                state_next = sts.reloc ? S_RM_RD : S_RESP;
            end
            S_RM_RD: begin
                ctl.op     = OP_RM_RD;
                state_next = S_RM_MV;
            end
            S_RM_MV: begin
                ctl.op     = OP_RM_MV;
                state_next = S_RM_FIX;
            end
            S_RM_FIX: begin
                ctl.op     = OP_RM_FIX;
                state_next = S_RESP;
            end
            S_RT: begin
                ctl.op     = OP_RT;
                state_next = S_RESP;
            end
            S_RESP: begin
                ctl.op = OP_RESP;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

>>> hw/rtl/pls_dpath.sv
// Datapath of the positional list store: request register, list head, tail
// and count, link walker, the three slot RAMs and the result register.
// Depends on pls_pkg and pls_ram.
module pls_dpath
    import pls_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  pls_in_t  s_data,
    input  pls_ctl_t ctl,
    output pls_sts_t sts,
    output logic     m_valid,
    input  logic     m_ready,
    output pls_out_t m_data
);

    localparam int SW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    pls_in_t               in_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [SW-1:0]         first_reg, first_next;
    logic [SW-1:0]         tail_reg, tail_next;
    logic [SW-1:0]         a_reg, a_next;
    logic [SW-1:0]         b_reg, b_next;
    logic [SW-1:0]         c_reg, c_next;
    logic [POS_W-1:0]      steps_reg, steps_next;
    logic                  started_reg, started_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [ITEM_WIDTH-1:0] res_item_reg, res_item_next;
    logic                  out_valid_reg, out_valid_next;
    pls_out_t              out_reg, out_next;

    logic                  item_we, next_we, prev_we;
    logic [SW-1:0]         item_waddr, next_waddr, prev_waddr;
    logic [ITEM_WIDTH-1:0] item_wdata;
    logic [SW-1:0]         next_wdata, prev_wdata;
    logic [SW-1:0]         rd_addr;
    logic [ITEM_WIDTH-1:0] item_rdata;
    logic [SW-1:0]         next_rdata, prev_rdata;

    logic [CMPW-1:0]       pos_x, cnt_x;
    logic [CW-1:0]         cnt_dec;
    logic [SW-1:0]         s_slot, walk_cur;
    logic                  bad_ins, bad_rr, full, mid, at_tail, out_free;
    logic [STAT_W-1:0]     chk_status;
    logic [ITEM_W-1:0]     item_ext;

    pls_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(DEPTH)) u_item_ram (
        .aclk  (aclk),
        .we    (item_we),
        .waddr (item_waddr),
        .wdata (item_wdata),
        .raddr (rd_addr),
        .rdata (item_rdata)
    );

    pls_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    pls_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    // Position checks against the current count.
    always_comb begin
        pos_x   = CMPW'(in_reg.position);
        cnt_x   = CMPW'(count_reg);
        cnt_dec = count_reg - CW'(1);
        s_slot  = count_reg[SW-1:0];
        bad_ins = (in_reg.position == '0) || (pos_x > cnt_x + CMPW'(1));
        bad_rr  = (in_reg.position == '0) || (pos_x > cnt_x);
        full    = (cnt_x == CMPW'(DEPTH));
        mid     = (pos_x <= cnt_x);
        at_tail = (pos_x == cnt_x);
        case (in_reg.cmd)
            CMD_INSERT:   chk_status = bad_ins ? RSP_BAD_POS : (full ? RSP_FULL : RSP_OK);
            CMD_REMOVE:   chk_status = bad_rr ? RSP_BAD_POS : RSP_OK;
            CMD_RETRIEVE: chk_status = bad_rr ? RSP_BAD_POS : RSP_OK;
            default:      chk_status = RSP_OK;
        endcase
        walk_cur = started_reg ? next_rdata : first_reg;
        out_free = !out_valid_reg || m_ready;
        item_ext = '0;
        item_ext[ITEM_WIDTH-1:0] = res_item_reg;
    end

    always_comb begin
        sts.cmd       = in_reg.cmd;
        sts.status    = chk_status;
        sts.pos_one   = (in_reg.position == POS_W'(1));
        sts.walk_done = (steps_reg == '0);
        sts.reloc     = (a_reg != cnt_dec[SW-1:0]) && (cnt_dec != '0);
        sts.out_free  = out_free;
    end

    always_comb begin
        count_next     = count_reg;
        first_next     = first_reg;
        tail_next      = tail_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        steps_next     = steps_reg;
        started_next   = started_reg;
        status_next    = status_reg;
        res_item_next  = res_item_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        item_we        = 1'b0;
        next_we        = 1'b0;
        prev_we        = 1'b0;
        item_waddr     = s_slot;
        next_waddr     = s_slot;
        prev_waddr     = s_slot;
        item_wdata     = in_reg.item_in[ITEM_WIDTH-1:0];
        next_wdata     = first_reg;
        prev_wdata     = s_slot;
        rd_addr        = a_reg;
        case (ctl.op)
            OP_CHECK: begin
                status_next   = chk_status;
                res_item_next = '0;
                started_next  = 1'b0;
                if (in_reg.cmd == CMD_INSERT) begin
                    steps_next = in_reg.position - POS_W'(2);
                end else begin
                    steps_next = in_reg.position - POS_W'(1);
                end
            end
            OP_WALK: begin
                rd_addr = walk_cur;
                if (steps_reg == '0) begin
                    a_next = walk_cur;
                end else begin
                    steps_next   = steps_reg - POS_W'(1);
                    started_next = 1'b1;
                end
            end
            OP_INS_HEAD: begin
                item_we = 1'b1;
                if (count_reg != '0) begin
                    next_we    = 1'b1;
                    prev_we    = 1'b1;
                    prev_waddr = first_reg;
                end else begin
                    tail_next = s_slot;
                end
                first_next = s_slot;
                count_next = count_reg + CW'(1);
            end
            OP_INS_A: begin
                item_we    = 1'b1;
                prev_we    = 1'b1;
                prev_wdata = a_reg;
                next_we    = mid;
                next_wdata = next_rdata;
                b_next     = next_rdata;
            end
            OP_INS_B: begin
                next_we    = 1'b1;
                next_waddr = a_reg;
                next_wdata = s_slot;
                if (mid) begin
                    prev_we    = 1'b1;
                    prev_waddr = b_reg;
                end else begin
                    tail_next = s_slot;
                end
                count_next = count_reg + CW'(1);
            end
            OP_RM_A: begin
                // Read data holds the links of the removed slot.
                if (in_reg.position == POS_W'(1)) begin
                    if (!at_tail) begin
                        first_next = next_rdata;
                    end
                end else if (!at_tail) begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = prev_rdata;
                end else begin
                    tail_next = prev_rdata;
                end
                count_next = cnt_dec;
            end
            OP_RM_RD: begin
                rd_addr = s_slot;
            end
            OP_RM_MV: begin
                item_we    = 1'b1;
                item_waddr = a_reg;
                item_wdata = item_rdata;
                next_we    = 1'b1;
                next_waddr = a_reg;
                next_wdata = next_rdata;
                prev_we    = 1'b1;
                prev_waddr = a_reg;
                prev_wdata = prev_rdata;
                b_next     = next_rdata;
                c_next     = prev_rdata;
            end
            OP_RM_FIX: begin
                if (s_slot == first_reg) begin
                    first_next = a_reg;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = c_reg;
                    next_wdata = a_reg;
                end
                if (s_slot == tail_reg) begin
                    tail_next = a_reg;
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = b_reg;
                    prev_wdata = a_reg;
                end
            end
            OP_RT: begin
                res_item_next = item_rdata;
            end
            OP_RESP: begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_next.status  = status_reg;
                    out_next.item_out = item_ext;
                    out_next.length  = cnt_x[LEN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            first_reg     <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            first_reg     <= first_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            in_reg <= s_data;
        end
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        steps_reg    <= steps_next;
        started_reg  <= started_next;
        status_reg   <= status_next;
        res_item_reg <= res_item_next;
        out_reg      <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
